// ----- hdl/flvp_pkg.sv -----
// Package for the FLV tag stream parser: parse phases, record kinds,
// configuration register indexes and the file signature.
// No dependencies.
`default_nettype none

package flvp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_SKIPOFF = 4'd1,
    PH_PREV    = 4'd2,
    PH_TAGHDR  = 4'd3,
    PH_AUDIO   = 4'd4,
    PH_VIDEO   = 4'd5,
    PH_AVC0    = 4'd6,
    PH_AVC1    = 4'd7,
    PH_AVC2    = 4'd8,
    PH_AVC3    = 4'd9,
    PH_SKIPPAY = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    REC_HEADER = 3'd0,
    REC_TAG    = 3'd1,
    REC_AUDIO  = 3'd2,
    REC_VIDEO  = 3'd3,
    REC_AVC    = 3'd4,
    REC_ERROR  = 3'd5
  } rec_kind_t;

  typedef enum logic [1:0] {
    CFG_AUDIO_CODE  = 2'd0,
    CFG_VIDEO_CODE  = 2'd1,
    CFG_SCRIPT_CODE = 2'd2,
    CFG_AVC_CODE    = 2'd3
  } cfg_index_t;

  // Error codes carried in code_high of an error record
  localparam logic [7:0] ERR_SIGNATURE = 8'd0;
  localparam logic [7:0] ERR_UNKNOWN_TAG = 8'd1;

  localparam logic [7:0] FLV_MAGIC [3] = '{8'h46, 8'h4C, 8'h56};

  localparam logic [31:0] HEADER_LEN = 32'd9;
  localparam logic [31:0] SIG_LEN = 32'd3;
  localparam logic [31:0] HDR_LAST = 32'd8;
  localparam logic [31:0] TAGHDR_LAST = 32'd10;
  localparam logic [31:0] PREV_LAST = 32'd3;

endpackage

`default_nettype wire

// ----- hdl/flv_tag_stream_parser.sv -----
// FLV tag stream parser: parse phase register, byte counter, field assembly
// and one record output register. Depends on flvp_pkg.
// Throughput: one byte per cycle; data_stall rises only while a finished
//   record sits in the output register and the consumer stalls it.
// Output: a record shows on record_valid in the cycle after the byte that completes it is taken.
// Reset: rst (synchronous, active high) restores the tag codes and header phase.
`default_nettype none

module flv_tag_stream_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  // byte request channel
  input  wire logic        data_valid,
  output logic             data_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        file_start,
  // record request channel
  output logic             record_valid,
  input  wire logic        record_stall,
  output logic [2:0]       record_kind,
  output logic [7:0]       tag_kind,
  output logic [23:0]      payload_size,
  output logic [23:0]      time_stamp,
  output logic [7:0]       time_stamp_ext,
  output logic [23:0]      stream_number,
  output logic [31:0]      size_word,
  output logic [7:0]       code_high,
  output logic [7:0]       code_low,
  // configuration writes
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // Tag code registers
  logic [7:0] audio_tag_code;
  logic [7:0] video_tag_code;
  logic [7:0] script_tag_code;
  logic [3:0] avc_codec_code;

  // Parser state
  flvp_pkg::phase_t parse_phase, parse_phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] assemble_word, assemble_word_next;
  logic [7:0]  held_tag_kind, held_tag_kind_next;
  logic [23:0] held_payload_size, held_payload_size_next;
  logic [23:0] held_time_stamp, held_time_stamp_next;
  logic [7:0]  held_time_ext, held_time_ext_next;
  logic [23:0] held_stream, held_stream_next;
  logic [31:0] held_prev_size, held_prev_size_next;
  logic [15:0] held_version_flags, held_version_flags_next;
  logic        error_stop, error_stop_next;

  // State as seen by the current byte (cleared when it starts a file)
  flvp_pkg::phase_t cur_phase;
  logic [31:0] cur_count;
  logic [31:0] cur_word;
  logic [7:0]  cur_tag_kind;
  logic [23:0] cur_payload_size;
  logic [23:0] cur_time_stamp;
  logic [7:0]  cur_time_ext;
  logic [23:0] cur_stream;
  logic [31:0] cur_prev_size;
  logic [15:0] cur_version_flags;
  logic        cur_error;

  // Record produced by the current byte
  logic                emit;
  flvp_pkg::rec_kind_t emit_kind;
  logic [31:0]         emit_word;
  logic [7:0]          emit_high;
  logic [7:0]          emit_low;

  // Payload countdown shared by every payload phase
  logic [31:0] count_dec;
  logic        payload_done;
  logic [23:0] avc_time;

  logic accept;
  logic drain;

  // Hold the byte channel only while a record waits on a stalled consumer
  assign data_stall = record_valid & record_stall;
  assign accept = data_valid & ~data_stall;
  assign drain = record_valid & ~record_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_tag_code <= 8'd8;
      video_tag_code <= 8'd9;
      script_tag_code <= 8'd18;
      avc_codec_code <= 4'd7;
    end else if (cfg_write) begin
      unique case (flvp_pkg::cfg_index_t'(cfg_index))
        flvp_pkg::CFG_AUDIO_CODE:  audio_tag_code <= cfg_data;
        flvp_pkg::CFG_VIDEO_CODE:  video_tag_code <= cfg_data;
        flvp_pkg::CFG_SCRIPT_CODE: script_tag_code <= cfg_data;
        flvp_pkg::CFG_AVC_CODE:    avc_codec_code <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // A file_start byte sees a freshly cleared parser
    if (file_start) begin
      cur_phase = flvp_pkg::PH_HEADER;
      cur_count = '0;
      cur_word = '0;
      cur_tag_kind = '0;
      cur_payload_size = '0;
      cur_time_stamp = '0;
      cur_time_ext = '0;
      cur_stream = '0;
      cur_prev_size = '0;
      cur_version_flags = '0;
      cur_error = 1'b0;
    end else begin
      cur_phase = parse_phase;
      cur_count = byte_count;
      cur_word = assemble_word;
      cur_tag_kind = held_tag_kind;
      cur_payload_size = held_payload_size;
      cur_time_stamp = held_time_stamp;
      cur_time_ext = held_time_ext;
      cur_stream = held_stream;
      cur_prev_size = held_prev_size;
      cur_version_flags = held_version_flags;
      cur_error = error_stop;
    end

    parse_phase_next = cur_phase;
    byte_count_next = cur_count;
    assemble_word_next = cur_word;
    held_tag_kind_next = cur_tag_kind;
    held_payload_size_next = cur_payload_size;
    held_time_stamp_next = cur_time_stamp;
    held_time_ext_next = cur_time_ext;
    held_stream_next = cur_stream;
    held_prev_size_next = cur_prev_size;
    held_version_flags_next = cur_version_flags;
    error_stop_next = cur_error;

    emit = 1'b0;
    emit_kind = flvp_pkg::REC_HEADER;
    emit_word = '0;
    emit_high = '0;
    emit_low = '0;

    count_dec = (cur_count != 32'd0) ? cur_count - 32'd1 : 32'd0;
    payload_done = (count_dec == 32'd0);
    avc_time = {cur_word[23:8], data_byte};

    if (!cur_error) begin
      unique case (cur_phase)
        flvp_pkg::PH_HEADER: begin
          if (cur_count < flvp_pkg::SIG_LEN &&
              data_byte != flvp_pkg::FLV_MAGIC[cur_count[1:0]]) begin
            // Bad signature: report once, then drop bytes until file_start
            error_stop_next = 1'b1;
            emit = 1'b1;
            emit_kind = flvp_pkg::REC_ERROR;
            emit_high = flvp_pkg::ERR_SIGNATURE;
          end else begin
            if (cur_count == 32'd3) begin
              held_version_flags_next = {data_byte, 8'd0};
            end else if (cur_count == 32'd4) begin
              held_version_flags_next = {cur_version_flags[15:8],
                                         cur_version_flags[7:0] | data_byte};
            end else if (cur_count >= 32'd5) begin
              assemble_word_next = {cur_word[23:0], data_byte};
            end
            if (cur_count < flvp_pkg::HDR_LAST) begin
              byte_count_next = cur_count + 32'd1;
            end else begin
              emit = 1'b1;
              emit_kind = flvp_pkg::REC_HEADER;
              emit_word = assemble_word_next;
              emit_high = held_version_flags_next[15:8];
              emit_low = held_version_flags_next[7:0];
              // Skip up to the data offset, if it lies past the header
              if (assemble_word_next > flvp_pkg::HEADER_LEN) begin
                byte_count_next = assemble_word_next - flvp_pkg::HEADER_LEN;
                parse_phase_next = flvp_pkg::PH_SKIPOFF;
              end else begin
                byte_count_next = '0;
                parse_phase_next = flvp_pkg::PH_PREV;
              end
            end
          end
        end

        flvp_pkg::PH_SKIPOFF: begin
          byte_count_next = count_dec;
          if (payload_done) begin
            parse_phase_next = flvp_pkg::PH_PREV;
          end
        end

        flvp_pkg::PH_PREV: begin
          held_prev_size_next = {cur_prev_size[23:0], data_byte};
          if (cur_count < flvp_pkg::PREV_LAST) begin
            byte_count_next = cur_count + 32'd1;
          end else begin
            byte_count_next = '0;
            parse_phase_next = flvp_pkg::PH_TAGHDR;
          end
        end

        flvp_pkg::PH_TAGHDR: begin
          if (cur_count == 32'd0) begin
            held_tag_kind_next = data_byte;
          end else if (cur_count <= 32'd3) begin
            held_payload_size_next = {cur_payload_size[15:0], data_byte};
          end else if (cur_count <= 32'd6) begin
            held_time_stamp_next = {cur_time_stamp[15:0], data_byte};
          end else if (cur_count == 32'd7) begin
            held_time_ext_next = data_byte;
          end else begin
            held_stream_next = {cur_stream[15:0], data_byte};
          end
          if (cur_count < flvp_pkg::TAGHDR_LAST) begin
            byte_count_next = cur_count + 32'd1;
          end else begin
            byte_count_next = {8'd0, cur_payload_size};
            emit = 1'b1;
            emit_kind = flvp_pkg::REC_TAG;
            emit_word = cur_prev_size;
            // Audio first, then video, then script when codes coincide
            priority if (cur_tag_kind == audio_tag_code) begin
              parse_phase_next = flvp_pkg::PH_AUDIO;
            end else if (cur_tag_kind == video_tag_code) begin
              parse_phase_next = flvp_pkg::PH_VIDEO;
            end else if (cur_tag_kind == script_tag_code) begin
              parse_phase_next = flvp_pkg::PH_SKIPPAY;
            end else begin
              error_stop_next = 1'b1;
              emit_kind = flvp_pkg::REC_ERROR;
              emit_word = '0;
              emit_high = flvp_pkg::ERR_UNKNOWN_TAG;
            end
            if (!error_stop_next && cur_payload_size == 24'd0) begin
              parse_phase_next = flvp_pkg::PH_PREV;
            end
          end
        end

        flvp_pkg::PH_AUDIO: begin
          emit = 1'b1;
          emit_kind = flvp_pkg::REC_AUDIO;
          emit_high = {4'd0, data_byte[7:4]};
          emit_low = {4'd0, data_byte[3:0]};
          byte_count_next = count_dec;
          parse_phase_next = payload_done ? flvp_pkg::PH_PREV : flvp_pkg::PH_SKIPPAY;
        end

        flvp_pkg::PH_VIDEO: begin
          emit = 1'b1;
          emit_kind = flvp_pkg::REC_VIDEO;
          emit_high = {4'd0, data_byte[7:4]};
          emit_low = {4'd0, data_byte[3:0]};
          byte_count_next = count_dec;
          if (payload_done) begin
            parse_phase_next = flvp_pkg::PH_PREV;
          end else if (data_byte[3:0] == avc_codec_code) begin
            parse_phase_next = flvp_pkg::PH_AVC0;
          end else begin
            parse_phase_next = flvp_pkg::PH_SKIPPAY;
          end
        end

        flvp_pkg::PH_AVC0: begin
          assemble_word_next = {data_byte, 24'd0};
          byte_count_next = count_dec;
          parse_phase_next = payload_done ? flvp_pkg::PH_PREV : flvp_pkg::PH_AVC1;
        end

        flvp_pkg::PH_AVC1: begin
          assemble_word_next = {cur_word[31:24], data_byte, cur_word[15:0]};
          byte_count_next = count_dec;
          parse_phase_next = payload_done ? flvp_pkg::PH_PREV : flvp_pkg::PH_AVC2;
        end

        flvp_pkg::PH_AVC2: begin
          assemble_word_next = {cur_word[31:16], data_byte, cur_word[7:0]};
          byte_count_next = count_dec;
          parse_phase_next = payload_done ? flvp_pkg::PH_PREV : flvp_pkg::PH_AVC3;
        end

        flvp_pkg::PH_AVC3: begin
          assemble_word_next = {cur_word[31:8], data_byte};
          emit = 1'b1;
          emit_kind = flvp_pkg::REC_AVC;
          emit_word = {{8{avc_time[23]}}, avc_time};
          emit_high = cur_word[31:24];
          byte_count_next = count_dec;
          parse_phase_next = payload_done ? flvp_pkg::PH_PREV : flvp_pkg::PH_SKIPPAY;
        end

        flvp_pkg::PH_SKIPPAY: begin
          byte_count_next = count_dec;
          parse_phase_next = payload_done ? flvp_pkg::PH_PREV : flvp_pkg::PH_SKIPPAY;
        end

        default: begin
          // Unused phase codes fall back to the header phase
          parse_phase_next = flvp_pkg::PH_HEADER;
          byte_count_next = '0;
        end
      endcase
    end
  end

  // Advance the parser on every accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= flvp_pkg::PH_HEADER;
      byte_count <= '0;
      assemble_word <= '0;
      held_tag_kind <= '0;
      held_payload_size <= '0;
      held_time_stamp <= '0;
      held_time_ext <= '0;
      held_stream <= '0;
      held_prev_size <= '0;
      held_version_flags <= '0;
      error_stop <= 1'b0;
    end else if (accept) begin
      parse_phase <= parse_phase_next;
      byte_count <= byte_count_next;
      assemble_word <= assemble_word_next;
      held_tag_kind <= held_tag_kind_next;
      held_payload_size <= held_payload_size_next;
      held_time_stamp <= held_time_stamp_next;
      held_time_ext <= held_time_ext_next;
      held_stream <= held_stream_next;
      held_prev_size <= held_prev_size_next;
      held_version_flags <= held_version_flags_next;
      error_stop <= error_stop_next;
    end
  end

  // Output register: load a new record, or drop the old one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      record_valid <= 1'b0;
    end else if (accept && emit) begin
      record_valid <= 1'b1;
    end else if (drain) begin
      record_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      record_kind <= emit_kind;
      tag_kind <= held_tag_kind_next;
      payload_size <= held_payload_size_next;
      time_stamp <= held_time_stamp_next;
      time_stamp_ext <= held_time_ext_next;
      stream_number <= held_stream_next;
      size_word <= emit_word;
      code_high <= emit_high;
      code_low <= emit_low;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/flvp_checker.sv -----
// Port-level checks for the FLV tag stream parser, bound to its top level.
// Depends on flvp_pkg.
`default_nettype none

module flvp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        data_valid,
  input wire logic        data_stall,
  input wire logic [7:0]  data_byte,
  input wire logic        file_start,
  input wire logic        record_valid,
  input wire logic        record_stall,
  input wire logic [2:0]  record_kind,
  input wire logic [7:0]  tag_kind,
  input wire logic [23:0] payload_size,
  input wire logic [23:0] time_stamp,
  input wire logic [7:0]  time_stamp_ext,
  input wire logic [23:0] stream_number,
  input wire logic [31:0] size_word,
  input wire logic [7:0]  code_high,
  input wire logic [7:0]  code_low,
  input wire logic        cfg_write,
  input wire logic [1:0]  cfg_index,
  input wire logic [7:0]  cfg_data
);

  logic unused_inputs;
  assign unused_inputs = data_valid ^ (^data_byte) ^ file_start ^ cfg_write ^
                         (^cfg_index) ^ (^cfg_data);

  // A stalled record holds its kind
  a_record_hold: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_stall |=> record_valid && $stable(record_kind))
    else $error("stalled record changed");

  // The byte side stalls only behind a waiting record
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> record_valid && record_stall)
    else $error("byte stall without a stalled record");

  // File header and signature error records carry cleared tag fields
  a_header_clear: assert property (@(posedge clk) disable iff (rst)
    record_valid && (record_kind == flvp_pkg::REC_HEADER ||
      (record_kind == flvp_pkg::REC_ERROR && code_high == flvp_pkg::ERR_SIGNATURE))
    |-> tag_kind == 8'd0 && payload_size == 24'd0 && time_stamp == 24'd0 &&
        time_stamp_ext == 8'd0 && stream_number == 24'd0)
    else $error("header record with stale tag fields");

  // Composition time is sign-extended from 24 bits
  a_avc_sign: assert property (@(posedge clk) disable iff (rst)
    record_valid && record_kind == flvp_pkg::REC_AVC
    |-> size_word[31:24] == {8{size_word[23]}} && code_low == 8'd0)
    else $error("avc record composition time not sign-extended");

  // Audio and video records decode one byte into two nibbles
  a_nibbles: assert property (@(posedge clk) disable iff (rst)
    record_valid && (record_kind == flvp_pkg::REC_AUDIO ||
      record_kind == flvp_pkg::REC_VIDEO)
    |-> code_high[7:4] == 4'd0 && code_low[7:4] == 4'd0 && size_word == 32'd0)
    else $error("media record fields out of range");

endmodule

bind flv_tag_stream_parser flvp_checker u_flvp_checker (.*);

`default_nettype wire
